>>> sv/pstb_pkg.sv
// Package for the periodic soft timer bank.
// Holds the command codes, the field widths and the layout of one slot word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pstb_pkg;

    localparam int SLOT_COUNT_DEFAULT = 4;

    localparam int OPCODE_W     = 3;
    localparam int SLOT_INDEX_W = 2;
    localparam int PERIOD_W     = 32;
    localparam int FIRED_W      = 4;
    localparam int IN_USE_W     = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 3'd0,
        OP_REGISTER = 3'd1,
        OP_START    = 3'd2,
        OP_STOP     = 3'd3,
        OP_RESUME   = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
    } slot_word_t;

endpackage

`default_nettype wire

>>> sv/periodic_soft_timer_bank.sv
// Top level of the periodic soft timer bank.
// Depends on pstb_pkg and on pstb_ram, which holds the period and count of each slot.
`timescale 1ns / 1ps
`default_nettype none

// Every command word yields one result word. Register, start, stop, resume and unknown
// commands finish in the cycle they are accepted. A tick walks the registered slots through
// the slot RAM, one read per slot per cycle, with the update of a slot written back while
// the next slot is read. The result register lets a new command be accepted in the cycle
// its predecessor's result is taken.
module periodic_soft_timer_bank
    import pstb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0: slot_index[1:0], period[33:2], zero fill.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: opcode[2:0].
    input  wire logic [OPCODE_W-1:0]  s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Fields from bit 0: fired[3:0], slots_in_use[6:4], rejected[7].
    output logic      [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           regcnt_reg, regcnt_next;
    logic [SLOT_COUNT-1:0]   en_reg, en_next;
    logic [CW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic                    pv_reg, pv_next;
    logic [AW-1:0]           pslot_reg, pslot_next;
    logic [FIRED_W-1:0]      fired_reg, fired_next;
    logic                    m_valid_reg, m_valid_next;
    logic [FIRED_W-1:0]      m_fired_reg, m_fired_next;
    logic [IN_USE_W-1:0]     m_inuse_reg, m_inuse_next;
    logic                    m_rej_reg, m_rej_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    slot_word_t              ram_wdata;
    slot_word_t              ram_rdata;

    logic                    in_acc;
    opcode_t                 op;
    logic [SLOT_INDEX_W-1:0] idx;
    logic [PERIOD_W-1:0]     per;
    logic                    idx_ok;
    logic [PERIOD_W-1:0]     cnt_inc;
    logic                    slot_hit;
    logic                    slot_fire;
    logic                    emit;
    logic                    rej;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign op            = opcode_t'(s_axis_tuser);
    assign idx           = s_axis_tdata[SLOT_INDEX_W-1:0];
    assign per           = s_axis_tdata[SLOT_INDEX_W +: PERIOD_W];
    assign idx_ok        = 32'(idx) < SLOT_COUNT;

    assign cnt_inc   = ram_rdata.count + PERIOD_W'(1);
    assign slot_hit  = pv_reg && (|(en_reg & (SLOT_COUNT'(1) << pslot_reg)));
    assign slot_fire = slot_hit && (cnt_inc >= ram_rdata.period);

    pstb_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        regcnt_next  = regcnt_reg;
        en_next      = en_reg;
        rd_ptr_next  = rd_ptr_reg;
        pv_next      = 1'b0;
        pslot_next   = pslot_reg;
        fired_next   = fired_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_fired_next = m_fired_reg;
        m_inuse_next = m_inuse_reg;
        m_rej_next   = m_rej_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        emit         = 1'b0;
        rej          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    emit = 1'b1;
                    unique case (op)
                        OP_TICK:
                        begin
                            emit        = 1'b0;
                            fired_next  = '0;
                            rd_ptr_next = '0;
                            state_next  = ST_WALK;
                        end
                        OP_REGISTER:
                        begin
                            if (regcnt_reg < SLOT_COUNT)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = regcnt_reg[AW-1:0];
                                ram_wdata.period = per;
                                ram_wdata.count  = '0;
                                en_next          = en_reg | (SLOT_COUNT'(1) << regcnt_reg);
                                regcnt_next      = regcnt_reg + CW'(1);
                            end
                            else
                            begin
                                rej = 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            if (idx_ok)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = AW'(idx);
                                ram_wdata.period = per;
                                ram_wdata.count  = '0;
                                en_next          = en_reg | (SLOT_COUNT'(1) << idx);
                            end
                        end
                        OP_STOP:
                        begin
                            if (idx_ok)
                            begin
                                en_next = en_reg & ~(SLOT_COUNT'(1) << idx);
                            end
                        end
                        OP_RESUME:
                        begin
                            if (idx_ok)
                            begin
                                en_next = en_reg | (SLOT_COUNT'(1) << idx);
                            end
                        end
                        default:
                        begin
                            rej = 1'b0;
                        end
                    endcase
                    if (emit)
                    begin
                        m_fired_next = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (rd_ptr_reg < regcnt_reg)
                begin
                    pv_next     = 1'b1;
                    pslot_next  = rd_ptr_reg[AW-1:0];
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                if (slot_hit)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = pslot_reg;
                    ram_wdata.period = ram_rdata.period;
                    ram_wdata.count  = slot_fire ? '0 : cnt_inc;
                end
                for (int i = 0; i < FIRED_W; i++)
                begin
                    if (slot_fire && (32'(pslot_reg) == i))
                    begin
                        fired_next[i] = 1'b1;
                    end
                end
                if (rd_ptr_reg == regcnt_reg)
                begin
                    emit         = 1'b1;
                    m_fired_next = fired_next;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            m_valid_next = 1'b1;
            m_inuse_next = IN_USE_W'(regcnt_next);
            m_rej_next   = rej;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            regcnt_reg  <= '0;
            en_reg      <= '0;
            rd_ptr_reg  <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            regcnt_reg  <= regcnt_next;
            en_reg      <= en_next;
            rd_ptr_reg  <= rd_ptr_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pslot_reg   <= pslot_next;
        fired_reg   <= fired_next;
        m_fired_reg <= m_fired_next;
        m_inuse_reg <= m_inuse_next;
        m_rej_reg   <= m_rej_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_rej_reg, m_inuse_reg, m_fired_reg};

    a_regcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        regcnt_reg <= SLOT_COUNT)
        else $error("registered slot count exceeds the bank size");

    a_inuse_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_inuse_reg == IN_USE_W'(regcnt_reg)))
        else $error("pending result disagrees with the registered slot count");

    a_pipe_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> ((state_reg == ST_WALK) && (CW'(pslot_reg) < regcnt_reg)))
        else $error("slot update outside the registered range");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_rej_reg) |-> (regcnt_reg == SLOT_COUNT))
        else $error("register rejected while the bank has a free slot");

    a_walk_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !m_valid_reg)
        else $error("result register occupied during a tick walk");

endmodule

`default_nettype wire

>>> sv/pstb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot period and count store; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pstb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> verif/tb_periodic_soft_timer_bank.sv
// Self-checking testbench for periodic_soft_timer_bank over its command and result streams.
// Predicts each result word and compares it with the output under random stalls on both sides.
// Depends on pstb_pkg and on the RTL of the timer bank.
`timescale 1ns / 1ps

module tb_periodic_soft_timer_bank;
    import pstb_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEFAULT;
    localparam logic [OPCODE_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNKNOWN_LAST  = 3'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 32'hFFFF_FFFF;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_WORDS    = 1090;

    typedef struct packed {
        logic                rejected;
        logic [IN_USE_W-1:0] slots_in_use;
        logic [FIRED_W-1:0]  fired;
    } timer_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OPCODE_W-1:0]  s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    timer_result_t       expected_results[$];
    logic [PERIOD_W-1:0] slot_period[SLOTS];
    logic [PERIOD_W-1:0] slot_count[SLOTS];
    logic                slot_on[SLOTS];
    logic [IN_USE_W-1:0] slots_used = '0;

    int error_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int rx_phase_left = 0;
    bit rx_choppy = 1'b0;

    periodic_soft_timer_bank #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic timer_result_t predict_timer_result(logic [OPCODE_W-1:0] op,
                                                           logic [SLOT_INDEX_W-1:0] idx,
                                                           logic [PERIOD_W-1:0] per);
        timer_result_t r;
        r = '0;
        case (op)
            OP_TICK:
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (s < slots_used && slot_on[s])
                    begin
                        slot_count[s] = slot_count[s] + 1;
                        if (slot_count[s] >= slot_period[s])
                        begin
                            slot_count[s] = '0;
                            r.fired[s] = 1'b1;
                        end
                    end
                end
            OP_REGISTER:
                if (slots_used < SLOTS)
                begin
                    slot_period[slots_used] = per;
                    slot_count[slots_used] = '0;
                    slot_on[slots_used] = 1'b1;
                    slots_used = IN_USE_W'(slots_used + 1);
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            OP_START:
                if (idx < SLOTS)
                begin
                    slot_period[idx] = per;
                    slot_count[idx] = '0;
                    slot_on[idx] = 1'b1;
                end
            OP_STOP:
                if (idx < SLOTS)
                    slot_on[idx] = 1'b0;
            OP_RESUME:
                if (idx < SLOTS)
                    slot_on[idx] = 1'b1;
            default:
                ;
        endcase
        r.slots_in_use = slots_used;
        return r;
    endfunction

    function automatic logic [PERIOD_W-1:0] random_period();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 6);
        else if (pick < 80)
            return $urandom_range(7, 40);
        else if (pick < 90)
            return PERIOD_MAX - $urandom_range(0, 3);
        return $urandom;
    endfunction

    function automatic logic [OPCODE_W-1:0] random_opcode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return OP_TICK;
        else if (pick < 58)
            return OP_REGISTER;
        else if (pick < 76)
            return OP_START;
        else if (pick < 87)
            return OP_STOP;
        else if (pick < 98)
            return OP_RESUME;
        return OPCODE_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
    endfunction

    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
        error_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken, or after a random idle gap.
    task automatic send_word(logic [OPCODE_W-1:0] op, logic [SLOT_INDEX_W-1:0] idx,
                             logic [PERIOD_W-1:0] per);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {{(S_TDATA_W - PERIOD_W - SLOT_INDEX_W){1'b0}}, per, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(predict_timer_result(op, idx, per));
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 12))
                    @(negedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic stop_sender();
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_random_word();
        send_word(random_opcode(), SLOT_INDEX_W'($urandom_range(0, SLOTS - 1)),
                  random_period());
    endtask

    task automatic test_idle_bank();
        send_word(OP_TICK, 0, 0);
        send_word(OP_UNKNOWN_FIRST, 3, PERIOD_MAX);
        send_word(OP_UNKNOWN_LAST, 0, 0);
        send_word(OP_STOP, 1, 0);
        send_word(OP_RESUME, 1, 0);
        send_word(OP_START, 2, 1);
        send_word(OP_TICK, 0, 0);
    endtask

    task automatic test_register_fill();
        send_word(OP_REGISTER, 0, 0);
        send_word(OP_REGISTER, 3, 1);
        send_word(OP_REGISTER, 0, PERIOD_MAX);
        send_word(OP_TICK, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_REGISTER, 0, 2);
        send_word(OP_REGISTER, 0, 5);
        send_word(OP_TICK, 0, 0);
        send_word(OP_TICK, 0, 0);
    endtask

    task automatic test_start_stop_resume();
        send_word(OP_STOP, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_RESUME, 0, 0);
        send_word(OP_START, 3, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_START, 1, PERIOD_MAX);
        send_word(OP_TICK, 0, 0);
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        repeat (30)
            send_random_word();
    endtask

    task automatic test_drain_pause();
        stop_sender();
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (10)
            send_random_word();
    endtask

    task automatic test_random_commands();
        repeat (RANDOM_WORDS)
            send_random_word();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_left = HOLD_OFF_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready = 1'b0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_choppy = 1'($urandom_range(0, 1));
                rx_phase_left = $urandom_range(20, 120);
            end
            else
            begin
                rx_phase_left--;
            end
            m_axis_tready = rx_choppy ? ($urandom_range(0, 9) < 6) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        timer_result_t got;
        timer_result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = timer_result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word, tdata", 0, m_axis_tdata);
            end
            else
            begin
                exp = expected_results.pop_front();
                if (got.fired !== exp.fired)
                    report_mismatch("fired", exp.fired, got.fired);
                if (got.slots_in_use !== exp.slots_in_use)
                    report_mismatch("slots_in_use", exp.slots_in_use, got.slots_in_use);
                if (got.rejected !== exp.rejected)
                    report_mismatch("rejected", exp.rejected, got.rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_period[s] = '0;
            slot_count[s] = '0;
            slot_on[s] = 1'b0;
        end
        burst_left = $urandom_range(1, 40);
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_idle_bank();
        test_register_fill();
        test_start_stop_resume();
        test_backpressure();
        test_drain_pause();
        test_random_commands();
        stop_sender();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/pstb_pkg.sv
sv/pstb_ram.sv
sv/periodic_soft_timer_bank.sv
verif/tb_periodic_soft_timer_bank.sv
